// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("checker assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("checker assertion failed");

`endif

// ===== rtl/ecpq_pkg.sv =====
// Package with the types and constants of the event calendar.
`default_nettype none
package ecpq_pkg;

    localparam int TIME_BITS     = 24;
    localparam int KIND_BITS     = 4;
    localparam int INFO_BITS     = 8;
    localparam int FILL_BITS     = 5;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef logic [FILL_BITS-1:0] t_fill;

    typedef struct packed {
        logic                 operation;
        logic [TIME_BITS-1:0] event_time;
        logic [KIND_BITS-1:0] event_kind;
        logic [INFO_BITS-1:0] event_info;
    } t_in_item;

    typedef struct packed {
        logic                 out_valid;
        logic [TIME_BITS-1:0] out_time;
        logic [KIND_BITS-1:0] out_kind;
        logic [INFO_BITS-1:0] out_info;
        logic                 was_empty;
        logic                 overflow;
        t_fill                fill_level;
    } t_out_item;

    // One stored event as it sits in a cell.
    typedef struct packed {
        logic [TIME_BITS-1:0] time_stamp;
        logic [KIND_BITS-1:0] kind;
        logic [INFO_BITS-1:0] info;
    } t_entry;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== rtl/ecpq_cell.sv =====
// One calendar cell: holds an event and trades it with its neighbors.
`default_nettype none
module ecpq_cell import ecpq_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_new,
    input  wire t_entry    i_left,
    input  wire logic      i_left_gt,
    input  wire logic      i_left_occ,
    input  wire t_entry    i_right,
    input  wire logic      i_occ,
    output t_entry         o_entry,
    output logic           o_gt
);

    t_entry r_entry;
    t_entry n_entry;

    // A cell is "greater" when it holds an event strictly later than the new one.
    // Since the chain is sorted, the greater cells form a tail.
    assign o_gt    = i_occ && (r_entry.time_stamp > i_new.time_stamp);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_left_gt) begin
                n_entry = i_left;
            end else if ((o_gt || !i_occ) && i_left_occ) begin
                n_entry = i_new;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

// ===== rtl/event_calendar_priority_queue_top.sv =====
// Top level of the event calendar: a sorted chain of cells and its fill count.
//
//   channel   direction  handshake            payload
//   command   in         i_start, o_busy      i_item   (t_in_item)
//   result    out        o_done (strobe)      o_result (t_out_item)
//
// Every accepted transaction gives one result on the cycle after it is taken.
// A new transaction can be taken in every cycle while o_busy is low, as every cell
// of the chain does its compare and shift at once.
// o_busy is high during reset and in the cycle after it; no clearing pass runs.
// The result strobe cannot be stalled by the receiver.
`default_nettype none
module event_calendar_priority_queue_top import ecpq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_in_item i_item,
    output logic          o_busy,
    output logic          o_done,
    output t_out_item     o_result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_busy;
    logic             r_done;
    t_out_item        r_result;
    t_out_item        n_result;

    logic      accept;
    logic      is_full;
    logic      is_empty;
    t_cell_ctl ctl;
    t_entry    new_entry;

    t_entry entry [DEPTH];
    logic   gt    [DEPTH];
    logic   occ   [DEPTH];

    assign accept   = i_start && !o_busy;
    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    assign ctl.ins = accept && (i_item.operation == OP_INSERT) && !is_full;
    assign ctl.rem = accept && (i_item.operation == OP_REMOVE) && !is_empty;

    assign new_entry.time_stamp = i_item.event_time;
    assign new_entry.kind       = i_item.event_kind;
    assign new_entry.info       = i_item.event_info;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        assign occ[gi] = (CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_head
            ecpq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_new      (new_entry),
                .i_left     (new_entry),
                .i_left_gt  (1'b0),
                .i_left_occ (1'b1),
                .i_right    (entry[(gi + 1) % DEPTH]),
                .i_occ      (occ[gi]),
                .o_entry    (entry[gi]),
                .o_gt       (gt[gi])
            );
        end else if (gi == DEPTH - 1) begin : g_tail
            ecpq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_new      (new_entry),
                .i_left     (entry[gi - 1]),
                .i_left_gt  (gt[gi - 1]),
                .i_left_occ (occ[gi - 1]),
                .i_right    ('0),
                .i_occ      (occ[gi]),
                .o_entry    (entry[gi]),
                .o_gt       (gt[gi])
            );
        end else begin : g_mid
            ecpq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_new      (new_entry),
                .i_left     (entry[gi - 1]),
                .i_left_gt  (gt[gi - 1]),
                .i_left_occ (occ[gi - 1]),
                .i_right    (entry[gi + 1]),
                .i_occ      (occ[gi]),
                .o_entry    (entry[gi]),
                .o_gt       (gt[gi])
            );
        end
    end

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_result            = '0;
        n_result.fill_level = t_fill'(n_count);
        if (i_item.operation == OP_INSERT) begin
            n_result.overflow = is_full;
        end else begin
            n_result.was_empty = is_empty;
            if (!is_empty) begin
                n_result.out_valid = 1'b1;
                n_result.out_time  = entry[0].time_stamp;
                n_result.out_kind  = entry[0].kind;
                n_result.out_info  = entry[0].info;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_busy  <= 1'b0;
            r_done  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    // Busy also covers the reset cycles themselves, so no transaction is taken then.
    assign o_busy   = r_busy || !i_rst_n;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== rtl/ecpq_checker.sv =====
// Port-level checker for the event calendar, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module ecpq_checker import ecpq_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_start,
    input wire t_in_item  i_item,
    input wire logic      o_busy,
    input wire logic      o_done,
    input wire t_out_item o_result
);

    // Every accepted transaction gives exactly one strobe on the next cycle.
    `ASSERT_CLK_RST(a_done_follows, i_clk, i_rst_n, (i_start && !o_busy) |=> o_done)
    `ASSERT_CLK_RST(a_no_spurious, i_clk, i_rst_n, !(i_start && !o_busy) |=> !o_done)

    // A remove never reports an overflow, and an insert never returns an event.
    `ASSERT_CLK_RST(a_remove_no_ovf, i_clk, i_rst_n, (i_start && !o_busy && (i_item.operation == OP_REMOVE)) |=> !o_result.overflow)
    `ASSERT_CLK_RST(a_insert_no_evt, i_clk, i_rst_n, (i_start && !o_busy && (i_item.operation == OP_INSERT)) |=> (!o_result.out_valid && !o_result.was_empty))

    // An empty report leaves the calendar empty.
    `ASSERT_CLK(a_empty_fill, i_clk, (i_rst_n && o_done && o_result.was_empty) |-> (o_result.fill_level == '0))

endmodule

bind event_calendar_priority_queue_top ecpq_checker u_ecpq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_item   (i_item),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);
`default_nettype wire
